// ===== hw/rtl/udec_pkg.sv =====
// Shared types and byte-class constants for the UTF-8 stream decoder.
`timescale 1ns / 1ps
package udec_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 22;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [BYTE_W-1:0] ASCII_LIMIT  = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD3_LIMIT  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_LIMIT  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD2_MASK   = 8'h3F;
  localparam logic [BYTE_W-1:0] LEAD3_MASK   = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD4_MASK   = 8'h0F;
  localparam logic [BYTE_W-1:0] CONT_MASK    = 8'h7F;

  // Following bytes still expected.
  typedef enum logic [1:0] {
    LEFT_NONE  = 2'd0,
    LEFT_ONE   = 2'd1,
    LEFT_TWO   = 2'd2,
    LEFT_THREE = 2'd3
  } left_t;

  // Result of one byte step, handed from the core to the output stage.
  typedef struct packed {
    logic            emit;
    logic [CP_W-1:0] code_point;
  } step_t;

endpackage

// ===== hw/rtl/udec_core.sv =====
// Sequence state and the one-byte decode step.
`timescale 1ns / 1ps
module udec_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  logic [udec_pkg::BYTE_W-1:0]   data_byte,
  output udec_pkg::step_t               step
);

  udec_pkg::left_t              left_r, left_nxt;
  logic [udec_pkg::CP_W-1:0]    acc_r, acc_nxt;
  logic [udec_pkg::CP_W-1:0]    acc_shift;
  logic [udec_pkg::BYTE_W-1:0]  cont_bits;

  assign cont_bits = data_byte & udec_pkg::CONT_MASK;
  assign acc_shift = {acc_r[udec_pkg::CP_W-7:0], 6'b0}
                   | {{(udec_pkg::CP_W-udec_pkg::BYTE_W){1'b0}}, cont_bits};

  always_comb begin
    left_nxt        = left_r;
    acc_nxt         = acc_r;
    step.emit       = 1'b0;
    step.code_point = acc_shift;
    case (left_r)
      udec_pkg::LEFT_NONE: begin
        step.code_point = {{(udec_pkg::CP_W-udec_pkg::BYTE_W){1'b0}}, data_byte};
        if (data_byte < udec_pkg::ASCII_LIMIT) begin
          step.emit = 1'b1;
        end else if (data_byte < udec_pkg::LEAD3_LIMIT) begin
          acc_nxt  = {{(udec_pkg::CP_W-udec_pkg::BYTE_W){1'b0}},
                      data_byte & udec_pkg::LEAD2_MASK};
          left_nxt = udec_pkg::LEFT_ONE;
        end else if (data_byte < udec_pkg::LEAD4_LIMIT) begin
          acc_nxt  = {{(udec_pkg::CP_W-udec_pkg::BYTE_W){1'b0}},
                      data_byte & udec_pkg::LEAD3_MASK};
          left_nxt = udec_pkg::LEFT_TWO;
        end else begin
          acc_nxt  = {{(udec_pkg::CP_W-udec_pkg::BYTE_W){1'b0}},
                      data_byte & udec_pkg::LEAD4_MASK};
          left_nxt = udec_pkg::LEFT_THREE;
        end
      end
      udec_pkg::LEFT_ONE: begin
        // last continuation: emit and clear
        step.emit = 1'b1;
        acc_nxt   = '0;
        left_nxt  = udec_pkg::LEFT_NONE;
      end
      udec_pkg::LEFT_TWO: begin
        acc_nxt  = acc_shift;
        left_nxt = udec_pkg::LEFT_ONE;
      end
      udec_pkg::LEFT_THREE: begin
        acc_nxt  = acc_shift;
        left_nxt = udec_pkg::LEFT_TWO;
      end
      default: begin
        left_nxt = udec_pkg::LEFT_NONE;
        acc_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= udec_pkg::LEFT_NONE;
      acc_r  <= '0;
    end else if (step_en) begin
      left_r <= left_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

// ===== hw/rtl/utf8_stream_decoder_top.sv =====
// Top level: UTF-8 byte stream in, code points out through a skid-buffered output.
// A code point is registered in out_cp_r, or in skid_cp_r while the consumer stalls.
// Throughput: one byte per cycle; in_tready drops only when both output slots hold
// results, which happens only while the consumer stalls.
// Reset (rst_n low, synchronous): drops any pending sequence and empties the output.
`timescale 1ns / 1ps
module utf8_stream_decoder_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [udec_pkg::BYTE_W-1:0]          in_tdata,   // [7:0] data_byte
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [udec_pkg::OUT_TDATA_W-1:0]     out_tdata   // [21:0] code_point, [23:22] zero
);

  udec_pkg::step_t             step;
  logic                        in_xfer;
  logic                        push;
  logic                        pop;
  logic                        out_valid_r;
  logic [udec_pkg::CP_W-1:0]   out_cp_r;
  logic                        skid_valid_r;
  logic [udec_pkg::CP_W-1:0]   skid_cp_r;

  assign in_tready = !skid_valid_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign push      = in_xfer && step.emit;
  assign pop       = out_valid_r && out_tready;

  udec_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_xfer),
    .data_byte (in_tdata),
    .step      (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // input is stalled; refill from the skid slot on transfer
      if (pop) begin
        out_cp_r     <= skid_cp_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_cp_r    <= step.code_point;
        out_valid_r <= 1'b1;
      end else begin
        skid_cp_r    <= step.code_point;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(udec_pkg::OUT_TDATA_W-udec_pkg::CP_W){1'b0}}, out_cp_r};

endmodule

// ===== hw/rtl/udec_checker.sv =====
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
`timescale 1ns / 1ps
module udec_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [udec_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result present right after reset");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with an empty output");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[udec_pkg::OUT_TDATA_W-1:udec_pkg::CP_W] == '0)
    else $error("code point exceeds 22 bits");

endmodule

bind utf8_stream_decoder_top udec_checker u_udec_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/sv/tb_utf8_stream_decoder_top.sv =====
// Self-checking testbench for the UTF-8 stream decoder with random byte streams.
`timescale 1ns / 1ps
module tb_utf8_stream_decoder_top;

  // Tracks the decode state and holds the code points still owed by the block.
  class cp_scoreboard;
    udec_pkg::left_t           bytes_due;
    logic [udec_pkg::CP_W-1:0] partial_cp;
    logic [udec_pkg::CP_W-1:0] pending_cps[$];
    int                        mismatches;

    function new();
      bytes_due  = udec_pkg::LEFT_NONE;
      partial_cp = '0;
      mismatches = 0;
    endfunction

    // Queue a code point at the tail.
    function void owe_cp(logic [udec_pkg::CP_W-1:0] cp);
      pending_cps = {pending_cps, cp};
    endfunction

    function void note_byte(logic [udec_pkg::BYTE_W-1:0] b);
      if (bytes_due == udec_pkg::LEFT_NONE) begin
        if (b < udec_pkg::ASCII_LIMIT) begin
          owe_cp(udec_pkg::CP_W'(b));
        end else if (b < udec_pkg::LEAD3_LIMIT) begin
          partial_cp = udec_pkg::CP_W'(b & udec_pkg::LEAD2_MASK);
          bytes_due  = udec_pkg::LEFT_ONE;
        end else if (b < udec_pkg::LEAD4_LIMIT) begin
          partial_cp = udec_pkg::CP_W'(b & udec_pkg::LEAD3_MASK);
          bytes_due  = udec_pkg::LEFT_TWO;
        end else begin
          partial_cp = udec_pkg::CP_W'(b & udec_pkg::LEAD4_MASK);
          bytes_due  = udec_pkg::LEFT_THREE;
        end
      end else begin
        // Shift out of the top, then OR in seven bits: bit 6 overlaps the old bit 0.
        partial_cp = {partial_cp[udec_pkg::CP_W-7:0], 6'b0}
                   | udec_pkg::CP_W'(b & udec_pkg::CONT_MASK);
        bytes_due  = udec_pkg::left_t'(bytes_due - 1);
        if (bytes_due == udec_pkg::LEFT_NONE) begin
          owe_cp(partial_cp);
          partial_cp = '0;
        end
      end
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [udec_pkg::OUT_TDATA_W-1:0] tdata);
      logic [udec_pkg::CP_W-1:0] want;
      if (pending_cps.size() == 0) begin
        report_mismatch($sformatf("unexpected code point 0x%06h",
                                  tdata[udec_pkg::CP_W-1:0]));
      end else begin
        want = pending_cps.pop_front();
        if (tdata[udec_pkg::CP_W-1:0] !== want)
          report_mismatch($sformatf("code point 0x%06h, want 0x%06h",
                                    tdata[udec_pkg::CP_W-1:0], want));
        if (tdata[udec_pkg::OUT_TDATA_W-1:udec_pkg::CP_W] !== '0)
          report_mismatch($sformatf("pad bits 0x%0h, want zero",
                                    tdata[udec_pkg::OUT_TDATA_W-1:udec_pkg::CP_W]));
      end
    endtask
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [udec_pkg::BYTE_W-1:0]      in_tdata;     // [7:0] data_byte
  logic                             out_tvalid;
  logic                             out_tready;
  logic [udec_pkg::OUT_TDATA_W-1:0] out_tdata;    // [21:0] code_point, [23:22] zero

  cp_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;

  // Extremes, every sequence length, and the permissive cases.
  logic [7:0] directed_seq [0:25] = '{
    8'h00, 8'h7F,                     // ASCII bounds
    8'h80, 8'h80,                     // stray continuation opens a 2-byte run
    8'hC3, 8'hA9,
    8'hDF, 8'hBF,
    8'hE2, 8'h82, 8'hAC,
    8'hEF, 8'hFF, 8'hFF,              // continuation not of form 10xxxxxx
    8'hF0, 8'h9F, 8'h98, 8'h80,
    8'hFF, 8'hFF, 8'hFF, 8'hFF,       // over-long lead, widest value
    8'hC2, 8'hE0,                     // lead taken as continuation
    8'hBF, 8'h41
  };

  utf8_stream_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Enter and leave at a falling edge; valid stays high into the next call.
  task send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b);
    @(negedge clk);
  endtask

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(99) < 80) return 8'h80 | 8'($urandom_range(63));
    return 8'($urandom_range(255));
  endfunction

  // Mostly well-formed sequences with random payload, some noise and truncated runs.
  task send_stream(input int count);
    int sent;
    int kind;
    int n_cont;
    logic [7:0] lead;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        send_byte(8'($urandom_range(8'h7F)));
        sent++;
      end else if (kind < 85) begin
        if (kind < 45) begin
          lead   = 8'($urandom_range(8'hDF, 8'h80));
          n_cont = 1;
        end else if (kind < 65) begin
          lead   = 8'($urandom_range(8'hEF, 8'hE0));
          n_cont = 2;
        end else begin
          lead   = 8'($urandom_range(8'hFF, 8'hF0));
          n_cont = 3;
        end
        send_byte(lead);
        sent++;
        repeat (n_cont) begin
          send_byte(cont_byte());
          sent++;
        end
      end else if (kind < 93) begin
        send_byte(8'($urandom_range(255)));
        sent++;
      end else begin
        send_byte(8'($urandom_range(8'hFF, 8'h80)));
        sent++;
        repeat ($urandom_range(1)) begin
          send_byte(8'($urandom_range(255)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    int guard;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_seq[i]) send_byte(directed_seq[i]);

    send_idle_pct = 0;  recv_stall_pct = 0;  send_stream(250);
    send_idle_pct = 67; recv_stall_pct = 0;  send_stream(200);
    send_idle_pct = 0;  recv_stall_pct = 67; send_stream(200);
    send_idle_pct = 30; recv_stall_pct = 30; send_stream(250);

    // Long receiver hold-off while bytes keep coming at full rate.
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_req = 100;
    send_stream(150);

    // Leave an unfinished three-byte run behind: it must produce nothing.
    send_byte(8'hE5);
    send_byte(8'h85);
    in_tvalid = 1'b0;

    guard = 0;
    while (sb.pending_cps.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (sb.pending_cps.size() != 0)
      sb.report_mismatch($sformatf("%0d code points never arrived", sb.pending_cps.size()));
    repeat (8) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
